// ===== hw/rtl/pst_pkg.sv =====
// ----------------------------------------------------------------------------
// pst_pkg
// Shared types, codes and widths for the peer slot table with idle aging.
// ----------------------------------------------------------------------------
package pst_pkg;

  localparam int SLOTS_DEF = 8;
  localparam int ADDR_W    = 32;
  localparam int IDLE_W    = 17;
  localparam int CTRL_W    = 6;
  localparam int SLOT_W    = 6;
  localparam int OCC_W     = 7;
  localparam int LIMIT_W   = 16;
  localparam int EV_W      = 3;
  localparam int ACT_W     = 2;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [IDLE_W-1:0]  IDLE_MAX  = '1;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 16'd100;

  // Register index, taken from paddr[2]
  localparam logic REG_IDLE_LIMIT = 1'b0;

  typedef enum logic [ACT_W-1:0] {
    ACT_TICK = 2'd0,
    ACT_JOIN = 2'd1,
    ACT_KEEP = 2'd2,
    ACT_CTRL = 2'd3
  } action_t;

  typedef enum logic [EV_W-1:0] {
    EV_JOINED    = 3'd0,
    EV_REFRESHED = 3'd1,
    EV_FULL      = 3'd2,
    EV_EXPIRED   = 3'd3,
    EV_ALIVE     = 3'd4,
    EV_UNKNOWN   = 3'd5,
    EV_STORED    = 3'd6,
    EV_DONE      = 3'd7
  } event_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_AGE_RD,
    ST_AGE_WR,
    ST_EXP_RD,
    ST_EXP_OUT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [IDLE_W-1:0] idle;
    logic [CTRL_W-1:0] ctrl;
  } entry_t;

  typedef struct packed {
    logic              re;
    logic [SLOT_W-1:0] raddr;
    logic              we;
    logic [SLOT_W-1:0] waddr;
    entry_t            wdata;
  } mem_req_t;

endpackage

// ===== hw/rtl/pst_mem.sv =====
// ----------------------------------------------------------------------------
// pst_mem
// Slot entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pst_mem
  import pst_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic     clk,
  input  mem_req_t req,
  output entry_t   rdata
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  entry_t mem_r [SLOTS];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr[AW-1:0]] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem_r[req.raddr[AW-1:0]];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/pst_cfg.sv =====
// ----------------------------------------------------------------------------
// pst_cfg
// APB-style register port holding the idle limit.
// ----------------------------------------------------------------------------
module pst_cfg
  import pst_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [LIMIT_W-1:0] idle_limit
);

  logic [LIMIT_W-1:0] limit_r;
  logic [LIMIT_W-1:0] limit_nxt;
  logic               wr_en;

  assign wr_en = psel && penable && pwrite && (paddr[2] == REG_IDLE_LIMIT);

  always_comb begin
    limit_nxt = limit_r;
    if (wr_en) begin
      limit_nxt = pwdata[LIMIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RST;
    end else begin
      limit_r <= limit_nxt;
    end
  end

  assign pready     = 1'b1;
  assign prdata     = (paddr[2] == REG_IDLE_LIMIT) ?
                      {{(PDATA_W-LIMIT_W){1'b0}}, limit_r} : '0;
  assign idle_limit = limit_r;

endmodule

// ===== hw/rtl/pst_ctrl.sv =====
// ----------------------------------------------------------------------------
// pst_ctrl
// Sequencer: address match, read-modify-write of slot entries, aging walk and
// the result register.
// ----------------------------------------------------------------------------
module pst_ctrl
  import pst_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [LIMIT_W-1:0] idle_limit,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [ACT_W-1:0]   in_action,
  input  logic [ADDR_W-1:0]  in_sender_addr,
  input  logic [CTRL_W-1:0]  in_control_bits,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [EV_W-1:0]    out_event_res,
  output logic [SLOT_W-1:0]  out_slot,
  output logic [ADDR_W-1:0]  out_peer_addr,
  output logic [CTRL_W-1:0]  out_controls,
  output logic [OCC_W-1:0]   out_occupied,
  output logic               out_last,
  output mem_req_t           mem_req,
  input  entry_t             mem_rdata
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0] SCAN_END = CW'(SLOTS);

  state_t state_r, state_nxt;

  action_t             act_r, act_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic [CTRL_W-1:0]   bits_r, bits_nxt;
  logic                hit_r, hit_nxt;
  logic                free_r, free_nxt;
  logic [SW-1:0]       slot_r, slot_nxt;
  logic [CW-1:0]       scan_r, scan_nxt;
  logic [SLOTS-1:0]    used_r, used_nxt;
  logic [SLOTS-1:0]    exp_r, exp_nxt;
  logic [OCC_W-1:0]    occ_r, occ_nxt;
  logic [ADDR_W-1:0]   tag_r [SLOTS];
  logic                tag_we;

  logic                ov_r, ov_nxt;
  event_t              oev_r, oev_nxt;
  logic [SLOT_W-1:0]   oslot_r, oslot_nxt;
  logic [ADDR_W-1:0]   oaddr_r, oaddr_nxt;
  logic [CTRL_W-1:0]   octrl_r, octrl_nxt;
  logic [OCC_W-1:0]    oocc_r, oocc_nxt;
  logic                olast_r, olast_nxt;

  logic                hit;
  logic [SW-1:0]       hit_idx;
  logic                free_any;
  logic [SW-1:0]       free_idx;
  logic                out_free;
  logic                accept;
  logic                scan_done;
  logic [SW-1:0]       scan_idx;
  logic [IDLE_W-1:0]   old_idle;
  logic [IDLE_W-1:0]   new_idle;
  logic                expire;
  logic [CTRL_W-1:0]   new_ctrl;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !ov_r || out_ready;
  assign scan_done = (scan_r == SCAN_END);
  assign scan_idx  = scan_r[SW-1:0];
  assign old_idle  = mem_rdata.idle;
  assign new_idle  = (old_idle != IDLE_MAX) ? old_idle + 1'b1 : old_idle;
  assign expire    = (old_idle >= {1'b0, idle_limit});
  assign new_ctrl  = (act_r == ACT_CTRL) ? bits_r : mem_rdata.ctrl;

  // Lowest used slot holding the sender, lowest free slot
  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (used_r[i] && (tag_r[i] == in_sender_addr)) begin
        hit     = 1'b1;
        hit_idx = SW'(i);
      end
      if (!used_r[i]) begin
        free_any = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (action_t'(in_action) == ACT_TICK) ? ST_AGE_RD : ST_ACC;
        end
      end
      ST_ACC: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_AGE_RD: begin
        if (scan_done) begin
          state_nxt = ST_EXP_RD;
        end else if (used_r[scan_idx]) begin
          state_nxt = ST_AGE_WR;
        end
      end
      ST_AGE_WR: begin
        state_nxt = ST_AGE_RD;
      end
      ST_EXP_RD: begin
        if (scan_done) begin
          state_nxt = ST_DONE;
        end else if (exp_r[scan_idx]) begin
          state_nxt = ST_EXP_OUT;
        end
      end
      ST_EXP_OUT: begin
        if (out_free) begin
          state_nxt = ST_EXP_RD;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath and outputs
  always_comb begin
    act_nxt   = act_r;
    addr_nxt  = addr_r;
    bits_nxt  = bits_r;
    hit_nxt   = hit_r;
    free_nxt  = free_r;
    slot_nxt  = slot_r;
    scan_nxt  = scan_r;
    used_nxt  = used_r;
    exp_nxt   = exp_r;
    occ_nxt   = occ_r;
    tag_we    = 1'b0;
    mem_req   = '0;

    ov_nxt    = ov_r && !out_ready;
    oev_nxt   = oev_r;
    oslot_nxt = oslot_r;
    oaddr_nxt = oaddr_r;
    octrl_nxt = octrl_r;
    oocc_nxt  = oocc_r;
    olast_nxt = olast_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          act_nxt  = action_t'(in_action);
          addr_nxt = in_sender_addr;
          bits_nxt = in_control_bits;
          hit_nxt  = hit;
          free_nxt = free_any;
          slot_nxt = hit ? hit_idx : free_idx;
          scan_nxt = '0;
          exp_nxt  = '0;
          if (hit && (action_t'(in_action) != ACT_TICK)) begin
            mem_req.re    = 1'b1;
            mem_req.raddr = SLOT_W'(hit_idx);
          end
        end
      end
      ST_ACC: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          olast_nxt = 1'b1;
          oslot_nxt = '0;
          oaddr_nxt = '0;
          octrl_nxt = '0;
          if (act_r == ACT_JOIN) begin
            if (hit_r) begin
              mem_req.we    = 1'b1;
              mem_req.waddr = SLOT_W'(slot_r);
              mem_req.wdata = '{addr: mem_rdata.addr, idle: '0, ctrl: mem_rdata.ctrl};
              oev_nxt   = EV_REFRESHED;
              oslot_nxt = SLOT_W'(slot_r);
              oaddr_nxt = mem_rdata.addr;
              octrl_nxt = mem_rdata.ctrl;
            end else if (free_r) begin
              // Claim the slot: entry, match tag and used mark together
              mem_req.we       = 1'b1;
              mem_req.waddr    = SLOT_W'(slot_r);
              mem_req.wdata    = '{addr: addr_r, idle: '0, ctrl: '0};
              tag_we           = 1'b1;
              used_nxt[slot_r] = 1'b1;
              occ_nxt          = OCC_W'(occ_r + 1'b1);
              oev_nxt   = EV_JOINED;
              oslot_nxt = SLOT_W'(slot_r);
              oaddr_nxt = addr_r;
            end else begin
              oev_nxt = EV_FULL;
            end
          end else begin
            if (hit_r) begin
              mem_req.we    = 1'b1;
              mem_req.waddr = SLOT_W'(slot_r);
              mem_req.wdata = '{addr: mem_rdata.addr, idle: '0, ctrl: new_ctrl};
              oev_nxt   = (act_r == ACT_CTRL) ? EV_STORED : EV_ALIVE;
              oslot_nxt = SLOT_W'(slot_r);
              oaddr_nxt = mem_rdata.addr;
              octrl_nxt = new_ctrl;
            end else begin
              oev_nxt = EV_UNKNOWN;
            end
          end
          oocc_nxt = occ_nxt;
        end
      end
      ST_AGE_RD: begin
        if (scan_done) begin
          scan_nxt = '0;
        end else if (used_r[scan_idx]) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = SLOT_W'(scan_idx);
        end else begin
          scan_nxt = CW'(scan_r + 1'b1);
        end
      end
      ST_AGE_WR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = SLOT_W'(scan_idx);
        mem_req.wdata = '{addr: mem_rdata.addr, idle: new_idle, ctrl: mem_rdata.ctrl};
        if (expire) begin
          used_nxt[scan_idx] = 1'b0;
          exp_nxt[scan_idx]  = 1'b1;
          occ_nxt            = OCC_W'(occ_r - 1'b1);
        end
        scan_nxt = CW'(scan_r + 1'b1);
      end
      ST_EXP_RD: begin
        if (!scan_done) begin
          if (exp_r[scan_idx]) begin
            mem_req.re    = 1'b1;
            mem_req.raddr = SLOT_W'(scan_idx);
          end else begin
            scan_nxt = CW'(scan_r + 1'b1);
          end
        end
      end
      ST_EXP_OUT: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          oev_nxt   = EV_EXPIRED;
          oslot_nxt = SLOT_W'(scan_idx);
          oaddr_nxt = mem_rdata.addr;
          octrl_nxt = mem_rdata.ctrl;
          oocc_nxt  = occ_r;
          olast_nxt = 1'b0;
          scan_nxt  = CW'(scan_r + 1'b1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          oev_nxt   = EV_DONE;
          oslot_nxt = '0;
          oaddr_nxt = '0;
          octrl_nxt = '0;
          oocc_nxt  = occ_r;
          olast_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      used_r  <= '0;
      exp_r   <= '0;
      occ_r   <= '0;
      ov_r    <= 1'b0;
      scan_r  <= '0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      exp_r   <= exp_nxt;
      occ_r   <= occ_nxt;
      ov_r    <= ov_nxt;
      scan_r  <= scan_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r   <= act_nxt;
    addr_r  <= addr_nxt;
    bits_r  <= bits_nxt;
    hit_r   <= hit_nxt;
    free_r  <= free_nxt;
    slot_r  <= slot_nxt;
    oev_r   <= oev_nxt;
    oslot_r <= oslot_nxt;
    oaddr_r <= oaddr_nxt;
    octrl_r <= octrl_nxt;
    oocc_r  <= oocc_nxt;
    olast_r <= olast_nxt;
  end

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_r[slot_r] <= addr_r;
    end
  end

  assign out_valid     = ov_r;
  assign out_event_res = oev_r;
  assign out_slot      = oslot_r;
  assign out_peer_addr = oaddr_r;
  assign out_controls  = octrl_r;
  assign out_occupied  = oocc_r;
  assign out_last      = olast_r;

`ifndef SYNTHESIS
  a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(used_r) == int'(occ_r))
    else $error("occupancy count out of step with used marks");

  a_exp_freed: assert property (@(posedge clk) disable iff (!rst_n)
    (exp_r & used_r) == '0)
    else $error("expired slot still marked used");

  a_mem_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_req.we && mem_req.re))
    else $error("entry read and write issued together");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != ST_IDLE))
    else $error("sequencer idle right after taking a request");
`endif

endmodule

// ===== hw/rtl/peer_slot_table_with_aging_top.sv =====
// A join, keepalive or control request is accepted in ST_IDLE; ST_ACC then
//   registers its result once the result register is free, and the next
//   request can be taken while that result is still held.
// A tick walks the slots twice: the aging pass reads and writes back each used
//   slot, the report pass emits a result per expired slot, then a done result.
// Reset (rst_n, synchronous): all slots free, idle_limit 100, no result held.
// ----------------------------------------------------------------------------
// peer_slot_table_with_aging_top
// Peer slot table with idle aging: joins claim or refresh slots, keepalive and
// control requests refresh a slot, ticks age used slots and free stale ones.
// ----------------------------------------------------------------------------
module peer_slot_table_with_aging_top
  import pst_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [ACT_W-1:0]   in_action,
  input  logic [ADDR_W-1:0]  in_sender_addr,
  input  logic [CTRL_W-1:0]  in_control_bits,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [EV_W-1:0]    out_event_res,
  output logic [SLOT_W-1:0]  out_slot,
  output logic [ADDR_W-1:0]  out_peer_addr,
  output logic [CTRL_W-1:0]  out_controls,
  output logic [OCC_W-1:0]   out_occupied,
  output logic               out_last,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  // Entry memory holds address, idle count and control bits per slot. The
  // used marks and a copy of each address (for the parallel match) sit in
  // flops inside the sequencer. A non-tick request reads its matched entry on
  // accept, writes back from ST_ACC; no two accesses to one entry overlap.

  logic [LIMIT_W-1:0] idle_limit;
  mem_req_t           mem_req;
  entry_t             mem_rdata;

  pst_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .idle_limit (idle_limit)
  );

  // Tick: first pass ages every used slot and marks the stale ones free;
  // second pass reports them, so each expired result carries final occupancy.
  pst_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .idle_limit      (idle_limit),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_sender_addr  (in_sender_addr),
    .in_control_bits (in_control_bits),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_event_res   (out_event_res),
    .out_slot        (out_slot),
    .out_peer_addr   (out_peer_addr),
    .out_controls    (out_controls),
    .out_occupied    (out_occupied),
    .out_last        (out_last),
    .mem_req         (mem_req),
    .mem_rdata       (mem_rdata)
  );

  pst_mem #(
    .SLOTS (SLOTS)
  ) u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

endmodule
